// ----- rtl/core/qrs_pkg.sv -----
package qrs_pkg;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_LINEAR = 2'd1,
      KIND_QUAD   = 2'd2
   } kind_type;

endpackage

// ----- rtl/core/qrs_req_if.sv -----
interface qrs_req_if #(
   parameter int WORD_BITS = 32
) ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] coef_a;
   logic signed [WORD_BITS-1:0] coef_b;
   logic signed [WORD_BITS-1:0] coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
   modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// ----- rtl/core/qrs_rsp_if.sv -----
interface qrs_rsp_if #(
   parameter int WORD_BITS = 32
) ();
   logic                        valid;
   logic                        ready;
   logic                        has_roots;
   logic signed [WORD_BITS-1:0] root_low;
   logic signed [WORD_BITS-1:0] root_high;
   logic                        overflow;

   modport source (output valid, output has_roots, output root_low, output root_high,
                   output overflow, input ready);
   modport sink   (input valid, input has_roots, input root_low, input root_high,
                   input overflow, output ready);
endinterface

// ----- rtl/core/quadratic_root_solver_core.sv -----
// Throughput: one item per cycle; the pipeline advances whenever the output register is
// empty or being taken. Sqrt takes one result bit per stage, each divider one quotient bit.
// Reset (synchronous, active high) clears the valid bits of all stages; data is not reset.
module quadratic_root_solver_core #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   qrs_req_if.sink   req_ch,
   qrs_rsp_if.source rsp_ch
);

   localparam int W    = WORD_BITS;
   localparam int H    = W / 2;
   localparam int RADW = 2 * W + 2;
   localparam int SW   = W + 1;
   localparam int RW   = SW + 3;
   localparam int NS   = W + 3;
   localparam int NW   = W + 2;
   localparam int NUMW = NW + FRAC_BITS;
   localparam int DENW = W + 1;
   localparam int DRW  = DENW + 1;

   typedef struct packed {
      logic [W-1:0]     a_mag;
      logic             an;
      logic [W-1:0]     b_mag;
      logic             bn;
      logic [W-1:0]     c_mag;
      logic             cn;
      qrs_pkg::kind_type kind;
   } side_type;

   logic en;
   logic rsp_valid_ff;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage 1: magnitudes
   logic     s1_valid_ff;
   side_type s1_side_ff, s1_side_in;

   always_comb begin
      s1_side_in       = '0;
      s1_side_in.an    = req_ch.coef_a[W-1];
      s1_side_in.bn    = req_ch.coef_b[W-1];
      s1_side_in.cn    = req_ch.coef_c[W-1];
      s1_side_in.a_mag = req_ch.coef_a[W-1] ? W'(-req_ch.coef_a) : W'(req_ch.coef_a);
      s1_side_in.b_mag = req_ch.coef_b[W-1] ? W'(-req_ch.coef_b) : W'(req_ch.coef_b);
      s1_side_in.c_mag = req_ch.coef_c[W-1] ? W'(-req_ch.coef_c) : W'(req_ch.coef_c);
      s1_side_in.kind  = qrs_pkg::KIND_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (en) begin
         s1_side_ff <= s1_side_in;
      end
   end

   // stage 2: partial products
   logic               s2_valid_ff;
   side_type           s2_side_ff;
   logic [W+H-1:0]     s2_bb_lo_ff, s2_ac_lo_ff;
   logic [2*W-H-1:0]   s2_bb_hi_ff, s2_ac_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_side_ff  <= s1_side_ff;
         s2_bb_lo_ff <= (W+H)'(s1_side_ff.b_mag) * (W+H)'(s1_side_ff.b_mag[H-1:0]);
         s2_bb_hi_ff <= (2*W-H)'(s1_side_ff.b_mag) * (2*W-H)'(s1_side_ff.b_mag[W-1:H]);
         s2_ac_lo_ff <= (W+H)'(s1_side_ff.a_mag) * (W+H)'(s1_side_ff.c_mag[H-1:0]);
         s2_ac_hi_ff <= (2*W-H)'(s1_side_ff.a_mag) * (2*W-H)'(s1_side_ff.c_mag[W-1:H]);
      end
   end

   // stage 3: sum partial products
   logic            s3_valid_ff;
   side_type        s3_side_ff;
   logic [RADW-1:0] s3_bsq_ff, s3_fac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_side_ff <= s2_side_ff;
         s3_bsq_ff  <= RADW'(s2_bb_lo_ff) + (RADW'(s2_bb_hi_ff) << H);
         s3_fac_ff  <= (RADW'(s2_ac_lo_ff) + (RADW'(s2_ac_hi_ff) << H)) << 2;
      end
   end

   // stage 4: discriminant and case selection
   logic [RADW-1:0] disc_in;
   side_type        side4_in;

   always_comb begin
      side4_in = s3_side_ff;
      disc_in  = s3_bsq_ff - s3_fac_ff;
      if (s3_side_ff.a_mag == '0) begin
         side4_in.kind = (s3_side_ff.b_mag == '0) ? qrs_pkg::KIND_NONE : qrs_pkg::KIND_LINEAR;
      end else if (s3_side_ff.an != s3_side_ff.cn && s3_side_ff.c_mag != '0) begin
         disc_in       = s3_bsq_ff + s3_fac_ff;
         side4_in.kind = qrs_pkg::KIND_QUAD;
      end else if (s3_bsq_ff < s3_fac_ff) begin
         side4_in.kind = qrs_pkg::KIND_NONE;
      end else begin
         side4_in.kind = qrs_pkg::KIND_QUAD;
      end
   end

   // square root stages, one result bit each
   logic            sq_valid_ff [SW+1];
   side_type        sq_side_ff  [SW+1];
   logic [RADW-1:0] sq_rad_ff   [SW+1];
   logic [SW-1:0]   sq_root_ff  [SW+1];
   logic [RW-1:0]   sq_rem_ff   [SW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (en) begin
         sq_valid_ff[0] <= s3_valid_ff;
      end
      if (en) begin
         sq_side_ff[0] <= side4_in;
         sq_rad_ff[0]  <= disc_in;
         sq_root_ff[0] <= '0;
         sq_rem_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      logic [RW-1:0] cand;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in;
      logic [SW-1:0] root_in;

      always_comb begin
         cand  = {sq_rem_ff[k][RW-3:0], sq_rad_ff[k][RADW-1 -: 2]};
         trial = RW'({sq_root_ff[k], 2'b01});
         if (cand >= trial) begin
            rem_in  = cand - trial;
            root_in = {sq_root_ff[k][SW-2:0], 1'b1};
         end else begin
            rem_in  = cand;
            root_in = {sq_root_ff[k][SW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
         if (en) begin
            sq_side_ff[k+1] <= sq_side_ff[k];
            sq_rad_ff[k+1]  <= {sq_rad_ff[k][RADW-3:0], 2'b00};
            sq_root_ff[k+1] <= root_in;
            sq_rem_ff[k+1]  <= rem_in;
         end
      end
   end

   // numerators and divisor
   side_type         ps;
   logic signed [NS-1:0] bv, sv, n1, n2, n1_neg, n2_neg;
   logic [NUMW-1:0]  num_in [2];
   logic [DENW-1:0]  den_in;
   logic             neg_in [2];

   always_comb begin
      ps     = sq_side_ff[SW];
      bv     = $signed({{(NS-W){1'b0}}, ps.b_mag});
      if (ps.bn) begin
         bv = -bv;
      end
      sv     = $signed({{(NS-SW){1'b0}}, sq_root_ff[SW]});
      n1     = -bv - sv;
      n2     = -bv + sv;
      n1_neg = -n1;
      n2_neg = -n2;
      if (ps.kind == qrs_pkg::KIND_LINEAR) begin
         num_in[0] = NUMW'(ps.c_mag) << FRAC_BITS;
         num_in[1] = NUMW'(ps.c_mag) << FRAC_BITS;
         den_in    = DENW'(ps.b_mag);
         neg_in[0] = ps.c_mag != '0 && ps.cn == ps.bn;
         neg_in[1] = ps.c_mag != '0 && ps.cn == ps.bn;
      end else begin
         num_in[0] = NUMW'(n1[NS-1] ? n1_neg[NW-1:0] : n1[NW-1:0]) << FRAC_BITS;
         num_in[1] = NUMW'(n2[NS-1] ? n2_neg[NW-1:0] : n2[NW-1:0]) << FRAC_BITS;
         den_in    = {ps.a_mag, 1'b0};
         neg_in[0] = n1[NS-1] != ps.an;
         neg_in[1] = n2[NS-1] != ps.an;
      end
   end

   // divider stages, two lanes, one quotient bit each
   logic              dv_valid_ff [NUMW+1];
   qrs_pkg::kind_type dv_kind_ff  [NUMW+1];
   logic [DENW-1:0]   dv_den_ff   [NUMW+1];
   logic              dv_neg_ff   [NUMW+1][2];
   logic [NUMW-1:0]   dv_num_ff   [NUMW+1][2];
   logic [NUMW-1:0]   dv_quo_ff   [NUMW+1][2];
   logic [DRW-1:0]    dv_rem_ff   [NUMW+1][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= sq_valid_ff[SW];
      end
      if (en) begin
         dv_kind_ff[0] <= ps.kind;
         dv_den_ff[0]  <= den_in;
         for (int l = 0; l < 2; l++) begin
            dv_neg_ff[0][l] <= neg_in[l];
            dv_num_ff[0][l] <= num_in[l];
            dv_quo_ff[0][l] <= '0;
            dv_rem_ff[0][l] <= '0;
         end
      end
   end

   for (genvar j = 0; j < NUMW; j++) begin : g_div
      logic [DRW-1:0]  cand [2];
      logic [DRW-1:0]  rem_in [2];
      logic [NUMW-1:0] quo_in [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            cand[l] = {dv_rem_ff[j][l][DRW-2:0], dv_num_ff[j][l][NUMW-1]};
            if (cand[l] >= DRW'(dv_den_ff[j])) begin
               rem_in[l] = cand[l] - DRW'(dv_den_ff[j]);
               quo_in[l] = {dv_quo_ff[j][l][NUMW-2:0], 1'b1};
            end else begin
               rem_in[l] = cand[l];
               quo_in[l] = {dv_quo_ff[j][l][NUMW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         if (en) begin
            dv_kind_ff[j+1] <= dv_kind_ff[j];
            dv_den_ff[j+1]  <= dv_den_ff[j];
            for (int l = 0; l < 2; l++) begin
               dv_neg_ff[j+1][l] <= dv_neg_ff[j][l];
               dv_num_ff[j+1][l] <= {dv_num_ff[j][l][NUMW-2:0], 1'b0};
               dv_quo_ff[j+1][l] <= quo_in[l];
               dv_rem_ff[j+1][l] <= rem_in[l];
            end
         end
      end
   end

   // saturate, order and output register
   localparam logic [NUMW-1:0] NEG_LIMIT = NUMW'(1) << (W - 1);
   localparam logic [NUMW-1:0] POS_LIMIT = NEG_LIMIT - NUMW'(1);
   localparam logic [W-1:0]    MIN_VAL   = W'(1) << (W - 1);
   localparam logic [W-1:0]    MAX_VAL   = MIN_VAL - W'(1);

   logic signed [W-1:0] sat [2];
   logic                sat_ovf [2];
   logic [NUMW-1:0]     quo_neg [2];
   logic                has_in, ovf_in;
   logic signed [W-1:0] low_in, high_in;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         quo_neg[l] = -dv_quo_ff[NUMW][l];
         sat_ovf[l] = 1'b0;
         if (dv_neg_ff[NUMW][l]) begin
            if (dv_quo_ff[NUMW][l] > NEG_LIMIT) begin
               sat_ovf[l] = 1'b1;
               sat[l]     = $signed(MIN_VAL);
            end else begin
               sat[l] = $signed(quo_neg[l][W-1:0]);
            end
         end else begin
            if (dv_quo_ff[NUMW][l] > POS_LIMIT) begin
               sat_ovf[l] = 1'b1;
               sat[l]     = $signed(MAX_VAL);
            end else begin
               sat[l] = $signed(dv_quo_ff[NUMW][l][W-1:0]);
            end
         end
      end
      has_in  = dv_kind_ff[NUMW] != qrs_pkg::KIND_NONE;
      ovf_in  = has_in && (sat_ovf[0] || sat_ovf[1]);
      low_in  = '0;
      high_in = '0;
      if (has_in) begin
         if (sat[0] > sat[1]) begin
            low_in  = sat[1];
            high_in = sat[0];
         end else begin
            low_in  = sat[0];
            high_in = sat[1];
         end
      end
   end

   logic                rsp_has_ff, rsp_ovf_ff;
   logic signed [W-1:0] rsp_low_ff, rsp_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid_ff[NUMW];
      end
      if (en) begin
         rsp_has_ff  <= has_in;
         rsp_ovf_ff  <= ovf_in;
         rsp_low_ff  <= low_in;
         rsp_high_ff <= high_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.has_roots = rsp_has_ff;
   assign rsp_ch.root_low  = rsp_low_ff;
   assign rsp_ch.root_high = rsp_high_ff;
   assign rsp_ch.overflow  = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_no_roots_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_ff |->
         rsp_low_ff == '0 && rsp_high_ff == '0 && !rsp_ovf_ff)
      else $error("no-root item carries nonzero fields");

   a_roots_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_has_ff |-> rsp_low_ff <= rsp_high_ff)
      else $error("roots out of order");

   a_ovf_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |->
         rsp_low_ff == $signed(MIN_VAL) || rsp_low_ff == $signed(MAX_VAL) ||
         rsp_high_ff == $signed(MIN_VAL) || rsp_high_ff == $signed(MAX_VAL))
      else $error("overflow without a saturated root");
`endif

endmodule
